// ===== sv/deqd_pkg.sv =====
// Shared types and constants for the double-ended queue with delete.
`default_nettype none

package deqd_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int OPCODE_W       = 3;
    localparam int IN_DATA_W      = 32;
    localparam int OUT_DATA_W     = 32;
    localparam int COUNT_W        = 5;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [OPCODE_W-1:0] OPC_PUSH_BACK  = 3'd0;
    localparam logic [OPCODE_W-1:0] OPC_POP_BACK   = 3'd1;
    localparam logic [OPCODE_W-1:0] OPC_PUSH_FRONT = 3'd2;
    localparam logic [OPCODE_W-1:0] OPC_POP_FRONT  = 3'd3;
    localparam logic [OPCODE_W-1:0] OPC_DELETE     = 3'd4;

    typedef enum logic [2:0] {
        OP_PUSH_BACK,
        OP_POP_BACK,
        OP_PUSH_FRONT,
        OP_POP_FRONT,
        OP_DELETE,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [IN_DATA_W-1:0] word;
    } t_cmd;

endpackage

`default_nettype wire

// ===== sv/deqd_ifs.sv =====
// Request and response channel interfaces of the double-ended queue.
`default_nettype none

interface deqd_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [deqd_pkg::OPCODE_W-1:0]          opcode;
    logic signed [deqd_pkg::IN_DATA_W-1:0]  data_in;

    modport source (output valid, output opcode, output data_in, input ready);
    modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

interface deqd_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [deqd_pkg::OUT_DATA_W-1:0] data_out;
    logic                                   empty_flag;
    logic                                   full_flag;
    logic                                   found;
    logic [deqd_pkg::COUNT_W-1:0]           entry_count;

    modport source (
        output valid, output data_out, output empty_flag, output full_flag,
        output found, output entry_count, input ready
    );
    modport sink (
        input valid, input data_out, input empty_flag, input full_flag,
        input found, input entry_count, output ready
    );
endinterface

`default_nettype wire

// ===== sv/deqd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module deqd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/deqd_front.sv =====
// Request intake: accepts beats, classifies the opcode and queues commands.
`default_nettype none

module deqd_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    deqd_req_if.sink          i_req,
    output logic              o_cmd_valid,
    input  wire logic         i_cmd_ready,
    output deqd_pkg::t_cmd    o_cmd
);

    localparam int QD  = deqd_pkg::QUEUE_DEPTH;
    localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    deqd_pkg::t_cmd r_q [QD];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    deqd_pkg::t_cmd w_new;
    logic           w_push;
    logic           w_pop;

    always_comb begin
        w_new.word = i_req.data_in;
        unique case (i_req.opcode)
            deqd_pkg::OPC_PUSH_BACK:  w_new.op = deqd_pkg::OP_PUSH_BACK;
            deqd_pkg::OPC_POP_BACK:   w_new.op = deqd_pkg::OP_POP_BACK;
            deqd_pkg::OPC_PUSH_FRONT: w_new.op = deqd_pkg::OP_PUSH_FRONT;
            deqd_pkg::OPC_POP_FRONT:  w_new.op = deqd_pkg::OP_POP_FRONT;
            deqd_pkg::OPC_DELETE:     w_new.op = deqd_pkg::OP_DELETE;
            default:                  w_new.op = deqd_pkg::OP_NOP;
        endcase
    end

    assign i_req.ready = (r_cnt != QCW'(QD));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_new;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QAW'(QD - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == QAW'(QD - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/deqd_back.sv =====
// Command execution: ring pointers, entry store, delete search and compaction.
`default_nettype none

module deqd_back #(
    parameter int DEPTH      = deqd_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deqd_pkg::DATA_WIDTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_ready,
    input  wire deqd_pkg::t_cmd i_cmd,
    deqd_rsp_if.source          o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = deqd_pkg::OUT_DATA_W;
    localparam int IW = deqd_pkg::IN_DATA_W;
    localparam int NW = deqd_pkg::COUNT_W;

    typedef enum logic [1:0] {S_IDLE, S_POP, S_SRCH, S_SHIFT} t_state;

    t_state                r_state,  n_state;
    logic [AW-1:0]         r_front,  n_front;
    logic [CW-1:0]         r_count,  n_count;
    logic [AW-1:0]         r_idx,    n_idx;
    logic [DATA_WIDTH-1:0] r_word,   n_word;
    logic                  r_pop_bk, n_pop_bk;
    logic                  r_ov,     n_ov;
    logic [OW-1:0]         r_od,     n_od;
    logic                  r_oe,     n_oe;
    logic                  r_of,     n_of;
    logic                  r_ofd,    n_ofd;
    logic [NW-1:0]         r_oc,     n_oc;

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [AW-1:0]         w_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;
    logic                  w_fire;
    logic                  w_load;
    logic                  w_full;
    logic                  w_empty;
    logic [CW-1:0]         w_cm1;
    logic [CW:0]           w_idx1;
    logic [CW:0]           w_idx2;
    logic [AW-1:0]         w_front_dec;
    logic [AW-1:0]         w_front_inc;
    logic [DATA_WIDTH-1:0] w_cmd_word;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] base,
                                              input logic [AW-1:0] k);
        logic [AW:0] s;
        logic [AW:0] d;
        s = {1'b0, base} + {1'b0, k};
        d = s - (AW+1)'(DEPTH);
        return (s >= (AW+1)'(DEPTH)) ? d[AW-1:0] : s[AW-1:0];
    endfunction

    function automatic logic [OW-1:0] f_to_out(input logic [DATA_WIDTH-1:0] w);
        logic [DATA_WIDTH+OW-1:0] t;
        t = {{OW{1'b0}}, w};
        return t[OW-1:0];
    endfunction

    function automatic logic [DATA_WIDTH-1:0] f_to_word(input logic [IW-1:0] x);
        logic [DATA_WIDTH+IW-1:0] t;
        t = {{DATA_WIDTH{1'b0}}, x};
        return t[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [NW-1:0] f_cnt_out(input logic [CW-1:0] c);
        logic [CW+NW-1:0] t;
        t = {{NW{1'b0}}, c};
        return t[NW-1:0];
    endfunction

    deqd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_cmd_ready = (r_state == S_IDLE) && (!r_ov || o_rsp.ready);
    assign w_fire      = i_cmd_valid && o_cmd_ready;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_cm1       = r_count - 1'b1;
    assign w_idx1      = (CW+1)'(r_idx) + 1'b1;
    assign w_idx2      = (CW+1)'(r_idx) + 2'd2;
    assign w_front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - 1'b1;
    assign w_front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + 1'b1;
    assign w_cmd_word  = f_to_word(i_cmd.word);

    always_comb begin
        n_state  = r_state;
        n_front  = r_front;
        n_count  = r_count;
        n_idx    = r_idx;
        n_word   = r_word;
        n_pop_bk = r_pop_bk;
        w_we     = 1'b0;
        w_waddr  = f_slot(r_front, r_count[AW-1:0]);
        w_wdata  = w_cmd_word;
        w_raddr  = r_front;
        w_load   = 1'b0;
        n_od     = '0;
        n_oe     = 1'b0;
        n_of     = 1'b0;
        n_ofd    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    unique case (i_cmd.op)
                        deqd_pkg::OP_PUSH_BACK: begin
                            w_load = 1'b1;
                            if (w_full) begin
                                n_of = 1'b1;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        deqd_pkg::OP_PUSH_FRONT: begin
                            w_load  = 1'b1;
                            w_waddr = w_front_dec;
                            if (w_full) begin
                                n_of = 1'b1;
                            end else begin
                                w_we    = 1'b1;
                                n_front = w_front_dec;
                                n_count = r_count + 1'b1;
                            end
                        end
                        deqd_pkg::OP_POP_BACK, deqd_pkg::OP_POP_FRONT: begin
                            n_pop_bk = (i_cmd.op == deqd_pkg::OP_POP_BACK);
                            if (i_cmd.op == deqd_pkg::OP_POP_BACK) begin
                                w_raddr = f_slot(r_front, w_cm1[AW-1:0]);
                            end
                            if (w_empty) begin
                                w_load = 1'b1;
                                n_oe   = 1'b1;
                                n_od   = f_to_out('1);
                            end else begin
                                n_state = S_POP;
                            end
                        end
                        deqd_pkg::OP_DELETE: begin
                            n_word = w_cmd_word;
                            n_idx  = '0;
                            if (w_empty) begin
                                w_load = 1'b1;
                            end else begin
                                n_state = S_SRCH;
                            end
                        end
                        default: begin
                            w_load = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                w_load  = 1'b1;
                n_od    = f_to_out(w_rdata);
                n_count = w_cm1;
                if (!r_pop_bk) begin
                    n_front = w_front_inc;
                end
                n_state = S_IDLE;
            end
            S_SRCH: begin
                w_raddr = f_slot(r_front, w_idx1[AW-1:0]);
                if (w_rdata == r_word) begin
                    if (w_idx1 < (CW+1)'(r_count)) begin
                        n_state = S_SHIFT;
                    end else begin
                        w_load  = 1'b1;
                        n_ofd   = 1'b1;
                        n_count = w_cm1;
                        n_state = S_IDLE;
                    end
                end else if (w_idx1 < (CW+1)'(r_count)) begin
                    n_idx = w_idx1[AW-1:0];
                end else begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SHIFT: begin
                w_we    = 1'b1;
                w_waddr = f_slot(r_front, r_idx);
                w_wdata = w_rdata;
                w_raddr = f_slot(r_front, w_idx2[AW-1:0]);
                if (w_idx2 < (CW+1)'(r_count)) begin
                    n_idx = w_idx1[AW-1:0];
                end else begin
                    w_load  = 1'b1;
                    n_ofd   = 1'b1;
                    n_count = w_cm1;
                    n_state = S_IDLE;
                end
            end
        endcase

        n_oc = f_cnt_out(n_count);
        n_ov = w_load || (r_ov && !o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_word   <= n_word;
        r_pop_bk <= n_pop_bk;
        if (w_load) begin
            r_od  <= n_od;
            r_oe  <= n_oe;
            r_of  <= n_of;
            r_ofd <= n_ofd;
            r_oc  <= n_oc;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.data_out    = r_od;
    assign o_rsp.empty_flag  = r_oe;
    assign o_rsp.full_flag   = r_of;
    assign o_rsp.found       = r_ofd;
    assign o_rsp.entry_count = r_oc;

endmodule

`default_nettype wire

// ===== sv/double_ended_queue_with_delete_unit.sv =====
// Top level of the bounded double-ended queue with delete-by-value.
//
//   Channel  Dir  Handshake      Beat contents
//   i_req    in   valid/ready    opcode, data_in
//   o_rsp    out  valid/ready    data_out, empty_flag, full_flag, found, entry_count
//
// A request enters a two-deep command queue and waits there until the
// execution unit takes it. Pushes, failed pops and other opcodes finish in
// the idle state, pops also pass S_POP because of the registered store read.
// A delete scans in S_SRCH up to the match and moves each later entry down
// one place in S_SHIFT. Reset clears the pointers and the count; the store
// needs no clearing. Requests are still taken while a response waits, until the queue fills.
`default_nettype none

module double_ended_queue_with_delete_unit #(
    parameter int DEPTH      = deqd_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deqd_pkg::DATA_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    deqd_req_if.sink  i_req,
    deqd_rsp_if.source o_rsp
);

    logic           w_cmd_valid;
    logic           w_cmd_ready;
    deqd_pkg::t_cmd w_cmd;

    deqd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    deqd_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

// ===== sim/tb_deqd_scoreboard_pkg.sv =====
// Scoreboard class for the double-ended queue: predicts and checks response beats.
package tb_deqd_scoreboard_pkg;

    import deqd_pkg::*;

    typedef struct packed {
        logic [OUT_DATA_W-1:0] data_out;
        logic                  empty_flag;
        logic                  full_flag;
        logic                  found;
        logic [COUNT_W-1:0]    entry_count;
    } t_outcome;

    class deqd_scoreboard;

        logic [IN_DATA_W-1:0] slots [DEPTH_DEF];
        int                   front;
        int                   held;
        t_outcome             awaited [$];
        int                   failures;

        function new();
            front    = 0;
            held     = 0;
            failures = 0;
        endfunction

        function int slot_of(int k);
            return (front + k) % DEPTH_DEF;
        endfunction

        function logic [IN_DATA_W-1:0] word_at(int k);
            return slots[slot_of(k)];
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_request(logic [OPCODE_W-1:0] op, logic [IN_DATA_W-1:0] word);
            t_outcome res;
            int       k;
            res = '0;
            case (op)
                OPC_PUSH_BACK: begin
                    if (held == DEPTH_DEF) begin
                        res.full_flag = 1'b1;
                    end else begin
                        slots[slot_of(held)] = word;
                        held++;
                    end
                end
                OPC_POP_BACK: begin
                    if (held == 0) begin
                        res.empty_flag = 1'b1;
                        res.data_out   = '1;
                    end else begin
                        res.data_out = slots[slot_of(held - 1)];
                        held--;
                    end
                end
                OPC_PUSH_FRONT: begin
                    if (held == DEPTH_DEF) begin
                        res.full_flag = 1'b1;
                    end else begin
                        front        = (front + DEPTH_DEF - 1) % DEPTH_DEF;
                        slots[front] = word;
                        held++;
                    end
                end
                OPC_POP_FRONT: begin
                    if (held == 0) begin
                        res.empty_flag = 1'b1;
                        res.data_out   = '1;
                    end else begin
                        res.data_out = slots[front];
                        front        = (front + 1) % DEPTH_DEF;
                        held--;
                    end
                end
                OPC_DELETE: begin
                    k = 0;
                    while (k < held && slots[slot_of(k)] != word) k++;
                    if (k < held) begin
                        for (; k + 1 < held; k++) slots[slot_of(k)] = slots[slot_of(k + 1)];
                        held--;
                        res.found = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            res.entry_count = COUNT_W'(held);
            awaited.push_back(res);
        endfunction

        function void compare_field(string name, logic [OUT_DATA_W-1:0] want,
                                    logic [OUT_DATA_W-1:0] got);
            if (want !== got) begin
                failures++;
                $error("%s: expected %0h, got %0h", name, want, got);
            end
        endfunction

        function void check_response(t_outcome got);
            t_outcome want;
            if (awaited.size() == 0) begin
                failures++;
                $error("response beat with nothing awaited: data_out %0h", got.data_out);
            end else begin
                want = awaited.pop_front();
                compare_field("data_out", want.data_out, got.data_out);
                compare_field("empty_flag", OUT_DATA_W'(want.empty_flag), OUT_DATA_W'(got.empty_flag));
                compare_field("full_flag", OUT_DATA_W'(want.full_flag), OUT_DATA_W'(got.full_flag));
                compare_field("found", OUT_DATA_W'(want.found), OUT_DATA_W'(got.found));
                compare_field("entry_count", OUT_DATA_W'(want.entry_count),
                              OUT_DATA_W'(got.entry_count));
            end
        endfunction

        function void close_out();
            if (awaited.size() != 0) begin
                failures++;
                $error("%0d response beats never arrived", awaited.size());
            end
        endfunction

    endclass

endpackage

// ===== sim/tb_double_ended_queue_with_delete_unit.sv =====
// Testbench top for the double-ended queue with delete: stimulus, handshakes and verdict.
module tb_double_ended_queue_with_delete_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import deqd_pkg::*;
    import tb_deqd_scoreboard_pkg::*;

    localparam logic [OPCODE_W-1:0] OPC_RESERVED_LO = 3'd5;
    localparam logic [OPCODE_W-1:0] OPC_RESERVED_HI = 3'd7;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 350;
    localparam int SETTLE_CYCLES = 40;
    localparam int PUSH_BIAS [3] = '{80, 20, 50};

    logic i_clk;
    logic i_rst_n;

    deqd_req_if req_if ();
    deqd_rsp_if rsp_if ();

    double_ended_queue_with_delete_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    deqd_scoreboard sb = new();

    int send_idle_pct = 26;
    int recv_idle_pct = 87;
    int recv_hold     = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic send_request(logic [OPCODE_W-1:0] op, logic [IN_DATA_W-1:0] word);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.opcode  <= op;
        req_if.data_in <= word;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(op, word);
    endtask

    task automatic await_drain();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [OPCODE_W-1:0] pick_op(int push_pct);
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 3) return OPCODE_W'($urandom_range(OPC_RESERVED_HI, OPC_RESERVED_LO));
        if (roll < 18) return OPC_DELETE;
        if ($urandom_range(99, 0) < push_pct)
            return $urandom_range(1, 0) ? OPC_PUSH_FRONT : OPC_PUSH_BACK;
        return $urandom_range(1, 0) ? OPC_POP_FRONT : OPC_POP_BACK;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pick_word(logic [OPCODE_W-1:0] op);
        if (op == OPC_DELETE && sb.held > 0 && $urandom_range(9, 0) < 7)
            return sb.word_at($urandom_range(sb.held - 1, 0));
        case ($urandom_range(9, 0))
            0, 1, 2: return IN_DATA_W'($urandom_range(5, 0));
            3: begin
                case ($urandom_range(3, 0))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic run_directed();
        logic [IN_DATA_W-1:0] word;
        send_request(OPC_POP_BACK, '0);
        send_request(OPC_POP_FRONT, '1);
        send_request(OPC_DELETE, '0);
        for (int r = OPC_RESERVED_LO; r <= OPC_RESERVED_HI; r++)
            send_request(OPCODE_W'(r), $urandom);
        for (int k = 0; k < DEPTH_DEF; k++) begin
            case (k)
                0: word = 32'h7FFF_FFFF;
                1: word = 32'h8000_0000;
                2: word = '0;
                3: word = '1;
                default: word = IN_DATA_W'(k % 3);
            endcase
            send_request(k[0] ? OPC_PUSH_FRONT : OPC_PUSH_BACK, word);
        end
        send_request(OPC_PUSH_BACK, 32'h0BAD_F00D);
        send_request(OPC_PUSH_FRONT, 32'h0BAD_F00D);
        send_request(OPC_DELETE, 32'd1);
        send_request(OPC_DELETE, 32'h1234_5678);
        req_if.valid <= 1'b0;
        await_drain();
    endtask

    task automatic run_random(int n, int s_idle, int r_idle, bit with_hold);
        logic [OPCODE_W-1:0] op;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < n; i++) begin
            if (with_hold && i == n / 2) recv_hold = HOLD_CYCLES;
            op = pick_op(PUSH_BIAS[(i / 48) % 3]);
            send_request(op, pick_word(op));
        end
        req_if.valid <= 1'b0;
        await_drain();
    endtask

    initial begin
        t_outcome got;
        forever begin
            if (recv_hold > 0) begin
                rsp_if.ready <= 1'b0;
                recv_hold--;
            end else begin
                rsp_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) begin
                got.data_out    = rsp_if.data_out;
                got.empty_flag  = rsp_if.empty_flag;
                got.full_flag   = rsp_if.full_flag;
                got.found       = rsp_if.found;
                got.entry_count = rsp_if.entry_count;
                sb.check_response(got);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_double_ended_queue_with_delete_unit NOT OK");
        $finish;
    end

    initial begin
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.opcode  <= OPC_PUSH_BACK;
        req_if.data_in <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random(PHASE_ITEMS, 26, 87, 1'b1);
        run_random(PHASE_ITEMS, 87, 26, 1'b0);
        run_random(PHASE_ITEMS, 0, 0, 1'b0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.close_out();
        if (sb.failures == 0) begin
            $display("tb_double_ended_queue_with_delete_unit OK");
        end else begin
            $display("tb_double_ended_queue_with_delete_unit NOT OK");
        end
        $finish;
    end

endmodule
